// ===== hdl/bpa_pkg.sv =====
// Shared constants and codes for the buddy page allocator.
package bpa_pkg;

	localparam int MAX_RANK   = 16;
	localparam int MAX_PAGES  = 32768;
	localparam int PAGE_BYTES = 4096;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int PG_W       = $clog2(MAX_PAGES);
	localparam int RANK_W     = 5;
	localparam int RIDX_W     = $clog2(MAX_RANK);
	localparam int LINK_W     = PG_W + 1;
	localparam int CNT_W      = 16;
	localparam int PCNT_W     = 16;

	localparam logic [7:0] ALLOC_MARK = 8'h80;
	localparam logic [6:0] RANK_MASK  = 7'h7F;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVAL   = 2'd1;
	localparam logic [1:0] ST_NOSPACE = 2'd2;

	localparam logic [2:0] MODE_INIT  = 3'd0;
	localparam logic [2:0] MODE_ALLOC = 3'd1;
	localparam logic [2:0] MODE_FREE  = 3'd2;
	localparam logic [2:0] MODE_QRANK = 3'd3;
	localparam logic [2:0] MODE_QCNT  = 3'd4;

	localparam logic CFG_BASE  = 1'b0;
	localparam logic CFG_PAGES = 1'b1;

endpackage

// ===== hdl/bpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/buddy_page_allocator_core.sv =====
// Buddy page allocator: sequencer over rank table and free-list link memories.
//
// channel  | dir | handshake            | payload
// s_axis   | in  | tvalid/tready        | tdata: address[31:0] rank[36:32]; tuser: mode
// m_axis   | out | tvalid/tready        | tdata: value[31:0]; tuser: status
// cfg      | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// Allocate and return proceed in split and merge steps, each paced by the read-then-write
// turnaround of the link and rank memories. Query rank: one rank table read per candidate rank.
// Init: one rank table clearing sweep over all MAX_PAGES entries, then one push per carved block.
// After reset the same clearing sweep runs before items are taken.
// A finished result sits in the output register; the next item is taken meanwhile.
module buddy_page_allocator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // address[31:0], rank[36:32], zero pad
	input  logic [2:0]  s_axis_tuser,   // mode[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // value[31:0]
	output logic [1:0]  m_axis_tuser,   // status[1:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int PG_W   = bpa_pkg::PG_W;
	localparam int RANK_W = bpa_pkg::RANK_W;
	localparam int RIDX_W = bpa_pkg::RIDX_W;
	localparam int LINK_W = bpa_pkg::LINK_W;
	localparam int CNT_W  = bpa_pkg::CNT_W;
	localparam int PCNT_W = bpa_pkg::PCNT_W;
	localparam int PSH    = bpa_pkg::PAGE_SHIFT;

	typedef enum logic [24:0] {
		S_IDLE    = 25'd1 << 0,
		S_CLEAR   = 25'd1 << 1,
		S_CARVE   = 25'd1 << 2,
		S_PUSH1   = 25'd1 << 3,
		S_PUSH2   = 25'd1 << 4,
		S_UNL1    = 25'd1 << 5,
		S_UNL2    = 25'd1 << 6,
		S_AFIND   = 25'd1 << 7,
		S_ALOOP   = 25'd1 << 8,
		S_AHEAD   = 25'd1 << 9,
		S_ASPLIT  = 25'd1 << 10,
		S_ASPLIT2 = 25'd1 << 11,
		S_AFINAL  = 25'd1 << 12,
		S_PAGE    = 25'd1 << 13,
		S_RD      = 25'd1 << 14,
		S_RCHK    = 25'd1 << 15,
		S_MERGE   = 25'd1 << 16,
		S_MCHK    = 25'd1 << 17,
		S_MUP     = 25'd1 << 18,
		S_MUP2    = 25'd1 << 19,
		S_QFIRST  = 25'd1 << 20,
		S_QST     = 25'd1 << 21,
		S_QCK     = 25'd1 << 22,
		S_QCNT    = 25'd1 << 23,
		S_DONE    = 25'd1 << 24
	} state_t;

	state_t state_q, ret_q;

	logic [31:0]       base_q;
	logic [PCNT_W-1:0] pages_q;
	logic [31:0]       region_base_q;
	logic [PCNT_W-1:0] region_pages_q;

	logic [2:0]        mode_q;
	logic [31:0]       addr_q;
	logic [RANK_W-1:0] want_q, cur_q, r_q, qr_q;
	logic [PG_W-1:0]   pg_q, ul_pg_q, push_pg_q, clr_q;
	logic [PCNT_W-1:0] carve_q;
	logic              pwr_q;

	logic [PG_W-1:0]   head_q [bpa_pkg::MAX_RANK];
	logic [bpa_pkg::MAX_RANK-1:0] head_ok_q;
	logic [CNT_W-1:0]  cnt_q  [bpa_pkg::MAX_RANK];

	logic [1:0]        res_st_q;
	logic [31:0]       res_val_q;
	logic              m_valid_q;
	logic [1:0]        m_st_q;
	logic [31:0]       m_val_q;

	// memory ports
	logic              rk_we;
	logic [PG_W-1:0]   rk_wa, rk_ra;
	logic [7:0]        rk_wd, rk_rd;
	logic              nx_we;
	logic [PG_W-1:0]   nx_wa;
	logic [LINK_W-1:0] nx_wd, nx_rd;
	logic              pv_we;
	logic [PG_W-1:0]   pv_wa;
	logic [LINK_W-1:0] pv_wd, pv_rd;

	bpa_ram #(.WIDTH(8), .DEPTH(bpa_pkg::MAX_PAGES)) u_rank_ram (
		.clk(clk), .we(rk_we), .waddr(rk_wa), .wdata(rk_wd), .raddr(rk_ra), .rdata(rk_rd)
	);
	bpa_ram #(.WIDTH(LINK_W), .DEPTH(bpa_pkg::MAX_PAGES)) u_next_ram (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(ul_pg_q), .rdata(nx_rd)
	);
	bpa_ram #(.WIDTH(LINK_W), .DEPTH(bpa_pkg::MAX_PAGES)) u_prev_ram (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(ul_pg_q), .rdata(pv_rd)
	);

	// rank index of the list being worked on
	logic [RANK_W-1:0] rm1;
	logic [RIDX_W-1:0] ridx;
	assign rm1  = r_q - RANK_W'(1);
	assign ridx = rm1[RIDX_W-1:0];

	// page decode of addr_q
	logic [31:0]     off;
	logic            page_ok;
	logic [PG_W-1:0] addr_page;
	assign off       = addr_q - region_base_q;
	assign page_ok   = (addr_q >= region_base_q) && (off[PSH-1:0] == '0) &&
	                   (off[31:PSH] < (32-PSH)'(region_pages_q));
	assign addr_page = off[PSH+PG_W-1:PSH];

	// largest aligned block that fits at carve_q
	logic [RANK_W-1:0] carve_rank;
	logic [PCNT_W-1:0] carve_bs, carve_left;
	always_comb begin
		logic [PCNT_W-1:0] bsz;
		carve_rank = '0;
		carve_bs   = '0;
		carve_left = region_pages_q - carve_q;
		for (int i = 0; i < bpa_pkg::MAX_RANK; i++) begin
			bsz = PCNT_W'(1) << i;
			if (bsz <= carve_left && (carve_q & (bsz - PCNT_W'(1))) == '0) begin
				carve_rank = RANK_W'(i + 1);
				carve_bs   = bsz;
			end
		end
	end

	// smallest non-empty list at or above want_q
	logic [RANK_W-1:0] find_rank;
	logic              find_ok;
	always_comb begin
		find_rank = '0;
		find_ok   = 1'b0;
		for (int i = bpa_pkg::MAX_RANK - 1; i >= 0; i--) begin
			if (head_ok_q[i] && RANK_W'(i + 1) >= want_q) begin
				find_rank = RANK_W'(i + 1);
				find_ok   = 1'b1;
			end
		end
	end

	logic [RANK_W-1:0] split_rank;
	logic [PG_W-1:0]   split_bs;
	logic [PG_W:0]     split_sum;
	logic [PG_W-1:0]   rbs, bud, low, qstart;
	assign split_rank = cur_q - RANK_W'(1);
	assign split_bs   = PG_W'(1) << (split_rank - RANK_W'(1));
	assign split_sum  = {1'b0, pg_q} + {1'b0, split_bs};
	assign rbs        = PG_W'(1) << rm1;
	assign bud        = pg_q ^ rbs;
	assign low        = (pg_q < ul_pg_q) ? pg_q : ul_pg_q;
	assign qstart     = pg_q & ~((PG_W'(1) << (qr_q - RANK_W'(1))) - PG_W'(1));

	logic [31:0] in_addr;
	logic [RANK_W-1:0] in_rank;
	logic in_acc, rank_bad_in;
	assign in_addr     = s_axis_tdata[31:0];
	assign in_rank     = s_axis_tdata[36:32];
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc      = s_axis_tvalid && s_axis_tready;
	assign rank_bad_in = (in_rank == '0) || (in_rank > RANK_W'(bpa_pkg::MAX_RANK));

	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_val_q;
	assign m_axis_tuser  = m_st_q;

	// memory port control
	always_comb begin
		rk_we = 1'b0;
		rk_wa = pg_q;
		rk_wd = '0;
		rk_ra = pg_q;
		nx_we = 1'b0;
		nx_wa = push_pg_q;
		nx_wd = {head_ok_q[ridx], head_q[ridx]};
		pv_we = 1'b0;
		pv_wa = push_pg_q;
		pv_wd = '0;
		unique case (state_q)
			S_CLEAR: begin
				rk_we = 1'b1;
				rk_wa = clr_q;
			end
			S_PUSH1: begin
				rk_we = pwr_q;
				rk_wa = push_pg_q;
				rk_wd = 8'(r_q);
				nx_we = 1'b1;
				pv_we = 1'b1;
			end
			S_PUSH2: begin
				pv_we = head_ok_q[ridx];
				pv_wa = head_q[ridx];
				pv_wd = {1'b1, push_pg_q};
			end
			S_UNL2: begin
				nx_we = pv_rd[PG_W];
				nx_wa = pv_rd[PG_W-1:0];
				nx_wd = nx_rd;
				pv_we = nx_rd[PG_W];
				pv_wa = nx_rd[PG_W-1:0];
				pv_wd = pv_rd;
			end
			S_AFINAL: begin
				rk_we = 1'b1;
				rk_wd = 8'(want_q) | bpa_pkg::ALLOC_MARK;
			end
			S_RCHK: begin
				rk_we = 1'b1;
				rk_wd = {1'b0, rk_rd[6:0]};
			end
			S_MERGE: rk_ra = bud;
			S_MUP: begin
				rk_we = 1'b1;
				rk_wa = low | rbs;
			end
			S_MUP2: begin
				rk_we = 1'b1;
				rk_wd = 8'(r_q + RANK_W'(1));
			end
			S_QST: rk_ra = qstart;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			ret_q          <= S_IDLE;
			base_q         <= '0;
			pages_q        <= '0;
			region_base_q  <= '0;
			region_pages_q <= '0;
			head_ok_q      <= '0;
			clr_q          <= '0;
			m_valid_q      <= 1'b0;
			for (int i = 0; i < bpa_pkg::MAX_RANK; i++) begin
				cnt_q[i]  <= '0;
				head_q[i] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					bpa_pkg::CFG_BASE:  base_q  <= cfg_data;
					bpa_pkg::CFG_PAGES: pages_q <= cfg_data[PCNT_W-1:0];
					default: ;
				endcase
			end
			if (m_valid_q && m_axis_tready && state_q != S_DONE) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						mode_q    <= s_axis_tuser;
						addr_q    <= in_addr;
						want_q    <= in_rank;
						r_q       <= in_rank;
						res_st_q  <= bpa_pkg::ST_INVAL;
						res_val_q <= '0;
						unique case (s_axis_tuser)
							bpa_pkg::MODE_INIT: begin
								if (17'(pages_q) <= 17'(bpa_pkg::MAX_PAGES)) begin
									region_base_q  <= base_q;
									region_pages_q <= pages_q;
									head_ok_q      <= '0;
									for (int i = 0; i < bpa_pkg::MAX_RANK; i++) begin
										cnt_q[i] <= '0;
									end
									clr_q   <= '0;
									carve_q <= '0;
									ret_q   <= S_CARVE;
									state_q <= S_CLEAR;
								end else begin
									state_q <= S_DONE;
								end
							end
							bpa_pkg::MODE_ALLOC: state_q <= rank_bad_in ? S_DONE : S_AFIND;
							bpa_pkg::MODE_FREE, bpa_pkg::MODE_QRANK: state_q <= S_PAGE;
							bpa_pkg::MODE_QCNT: state_q <= rank_bad_in ? S_DONE : S_QCNT;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + PG_W'(1);
					if (clr_q == '1) state_q <= ret_q;
				end
				S_CARVE: begin
					if (carve_q >= region_pages_q) begin
						res_st_q <= bpa_pkg::ST_OK;
						state_q  <= S_DONE;
					end else begin
						r_q       <= carve_rank;
						push_pg_q <= carve_q[PG_W-1:0];
						pwr_q     <= 1'b1;
						carve_q   <= carve_q + carve_bs;
						ret_q     <= S_CARVE;
						state_q   <= S_PUSH1;
					end
				end
				S_PUSH1: state_q <= S_PUSH2;
				S_PUSH2: begin
					head_q[ridx]    <= push_pg_q;
					head_ok_q[ridx] <= 1'b1;
					cnt_q[ridx]     <= cnt_q[ridx] + CNT_W'(1);
					state_q         <= ret_q;
				end
				S_UNL1: state_q <= S_UNL2;
				S_UNL2: begin
					if (!pv_rd[PG_W]) begin
						head_q[ridx]    <= nx_rd[PG_W-1:0];
						head_ok_q[ridx] <= nx_rd[PG_W];
					end
					if (cnt_q[ridx] != '0) cnt_q[ridx] <= cnt_q[ridx] - CNT_W'(1);
					state_q <= ret_q;
				end
				S_AFIND: begin
					if (find_ok) begin
						cur_q   <= find_rank;
						state_q <= S_ALOOP;
					end else begin
						res_st_q <= bpa_pkg::ST_NOSPACE;
						state_q  <= S_DONE;
					end
				end
				S_ALOOP: begin
					if (cur_q > want_q) begin
						r_q   <= cur_q;
						ret_q <= S_ASPLIT;
					end else begin
						r_q   <= want_q;
						ret_q <= S_AFINAL;
					end
					state_q <= S_AHEAD;
				end
				S_AHEAD: begin
					pg_q    <= head_q[ridx];
					ul_pg_q <= head_q[ridx];
					state_q <= S_UNL1;
				end
				S_ASPLIT: begin
					cur_q <= split_rank;
					r_q   <= split_rank;
					pwr_q <= 1'b1;
					if (!split_sum[PG_W]) begin
						push_pg_q <= split_sum[PG_W-1:0];
						ret_q     <= S_ASPLIT2;
						state_q   <= S_PUSH1;
					end else begin
						state_q <= S_ASPLIT2;
					end
				end
				S_ASPLIT2: begin
					push_pg_q <= pg_q;
					pwr_q     <= 1'b1;
					ret_q     <= S_ALOOP;
					state_q   <= S_PUSH1;
				end
				S_AFINAL: begin
					res_st_q  <= bpa_pkg::ST_OK;
					res_val_q <= region_base_q + (32'(pg_q) << PSH);
					state_q   <= S_DONE;
				end
				S_PAGE: begin
					pg_q    <= addr_page;
					state_q <= page_ok ? S_RD : S_DONE;
				end
				S_RD: state_q <= (mode_q == bpa_pkg::MODE_FREE) ? S_RCHK : S_QFIRST;
				S_RCHK: begin
					if (rk_rd[6:0] == '0 || (rk_rd & bpa_pkg::ALLOC_MARK) == '0 ||
					    rk_rd[6:0] > 7'(bpa_pkg::MAX_RANK)) begin
						state_q <= S_DONE;
					end else begin
						r_q     <= rk_rd[RANK_W-1:0];
						state_q <= S_MERGE;
					end
				end
				S_MERGE: begin
					if (r_q < RANK_W'(bpa_pkg::MAX_RANK) && PCNT_W'(bud) < region_pages_q) begin
						ul_pg_q <= bud;
						state_q <= S_MCHK;
					end else begin
						push_pg_q <= pg_q;
						pwr_q     <= 1'b0;
						res_st_q  <= bpa_pkg::ST_OK;
						ret_q     <= S_DONE;
						state_q   <= S_PUSH1;
					end
				end
				S_MCHK: begin
					if (rk_rd == 8'(r_q)) begin
						ret_q   <= S_MUP;
						state_q <= S_UNL1;
					end else begin
						push_pg_q <= pg_q;
						pwr_q     <= 1'b0;
						res_st_q  <= bpa_pkg::ST_OK;
						ret_q     <= S_DONE;
						state_q   <= S_PUSH1;
					end
				end
				S_MUP: begin
					pg_q    <= low;
					state_q <= S_MUP2;
				end
				S_MUP2: begin
					r_q     <= r_q + RANK_W'(1);
					state_q <= S_MERGE;
				end
				S_QFIRST: begin
					if (rk_rd[6:0] != '0) begin
						res_st_q  <= bpa_pkg::ST_OK;
						res_val_q <= 32'(rk_rd[6:0]);
						state_q   <= S_DONE;
					end else begin
						qr_q    <= RANK_W'(bpa_pkg::MAX_RANK);
						state_q <= S_QST;
					end
				end
				S_QST: begin
					if (qr_q == '0) begin
						state_q <= S_DONE;
					end else if (qstart == pg_q) begin
						qr_q <= qr_q - RANK_W'(1);
					end else begin
						state_q <= S_QCK;
					end
				end
				S_QCK: begin
					if (rk_rd[6:0] == 7'(qr_q)) begin
						res_st_q  <= bpa_pkg::ST_OK;
						res_val_q <= 32'(qr_q);
						state_q   <= S_DONE;
					end else begin
						qr_q    <= qr_q - RANK_W'(1);
						state_q <= S_QST;
					end
				end
				S_QCNT: begin
					res_st_q  <= bpa_pkg::ST_OK;
					res_val_q <= 32'(cnt_q[ridx]);
					state_q   <= S_DONE;
				end
				S_DONE: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_st_q    <= res_st_q;
						m_val_q   <= (res_st_q == bpa_pkg::ST_OK) ? res_val_q : '0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_split_above_want: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ASPLIT |-> cur_q > want_q)
		else $error("split below requested rank");

	a_merge_rank: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MERGE |-> r_q != '0 && r_q <= RANK_W'(bpa_pkg::MAX_RANK))
		else $error("merge rank out of range");

	a_carve_fits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CARVE && carve_q < region_pages_q |-> carve_rank != '0)
		else $error("no block fits while carving");

endmodule

// ===== tb/buddy_page_allocator_core_test.sv =====
// Self-checking testbench for the buddy page allocator core, with a built-in free-list predictor.
`timescale 1ns / 100ps

module buddy_page_allocator_core_test;

	localparam int MAX_RANK   = bpa_pkg::MAX_RANK;
	localparam int MAX_PAGES  = bpa_pkg::MAX_PAGES;
	localparam int PAGE_BYTES = bpa_pkg::PAGE_BYTES;
	localparam logic [7:0] ALLOC_MARK = bpa_pkg::ALLOC_MARK;
	localparam logic [6:0] RANK_MASK  = bpa_pkg::RANK_MASK;
	localparam logic [1:0] ST_OK      = bpa_pkg::ST_OK;
	localparam logic [1:0] ST_INVAL   = bpa_pkg::ST_INVAL;
	localparam logic [1:0] ST_NOSPACE = bpa_pkg::ST_NOSPACE;
	localparam logic [2:0] MODE_INIT  = bpa_pkg::MODE_INIT;
	localparam logic [2:0] MODE_ALLOC = bpa_pkg::MODE_ALLOC;
	localparam logic [2:0] MODE_FREE  = bpa_pkg::MODE_FREE;
	localparam logic [2:0] MODE_QRANK = bpa_pkg::MODE_QRANK;
	localparam logic [2:0] MODE_QCNT  = bpa_pkg::MODE_QCNT;
	localparam logic CFG_BASE  = bpa_pkg::CFG_BASE;
	localparam logic CFG_PAGES = bpa_pkg::CFG_PAGES;

	localparam int LIMIT = 4000000;
	localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
	localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] value;
	} answer_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = 0;
	logic [2:0]  s_axis_tuser = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic        cfg_index = 0;
	logic [31:0] cfg_data = 0;

	buddy_page_allocator_core dut (.*);

	always #6 clk = ~clk;

	// allocator shadow state
	logic [31:0] shadow_base, shadow_pages, region_base, region_pages;
	logic [7:0]  rank_tbl [MAX_PAGES];
	int unsigned nxt [MAX_PAGES];
	int unsigned prv [MAX_PAGES];
	bit          nxt_ok [MAX_PAGES];
	bit          prv_ok [MAX_PAGES];
	int unsigned head [MAX_RANK];
	bit          head_ok [MAX_RANK];
	int unsigned free_cnt [MAX_RANK];

	answer_t     pending_answers [$];
	logic [31:0] held_blocks [$];
	int          errors = 0;
	int          cycles = 0;
	int          send_idle = 0;
	int          recv_idle = 0;
	int          mode_seen [8];
	int          ok_seen = 0;

	function automatic void wipe_tables();
		for (int i = 0; i < MAX_PAGES; i++) begin
			rank_tbl[i] = 0; nxt[i] = 0; prv[i] = 0; nxt_ok[i] = 0; prv_ok[i] = 0;
		end
		for (int r = 0; r < MAX_RANK; r++) begin
			head[r] = 0; head_ok[r] = 0; free_cnt[r] = 0;
		end
	endfunction

	function automatic void push_free(int unsigned r, int unsigned pg);
		if (r < 1 || r > MAX_RANK || pg >= MAX_PAGES) return;
		nxt[pg] = head[r-1];
		nxt_ok[pg] = head_ok[r-1];
		prv_ok[pg] = 0;
		if (head_ok[r-1] && head[r-1] < MAX_PAGES) begin
			prv[head[r-1]] = pg;
			prv_ok[head[r-1]] = 1;
		end
		head[r-1] = pg;
		head_ok[r-1] = 1;
		free_cnt[r-1]++;
	endfunction

	function automatic void unlink_free(int unsigned r, int unsigned pg);
		if (r < 1 || r > MAX_RANK || pg >= MAX_PAGES) return;
		if (prv_ok[pg] && prv[pg] < MAX_PAGES) begin
			nxt[prv[pg]] = nxt[pg];
			nxt_ok[prv[pg]] = nxt_ok[pg];
		end else begin
			head[r-1] = nxt[pg];
			head_ok[r-1] = nxt_ok[pg];
		end
		if (nxt_ok[pg] && nxt[pg] < MAX_PAGES) begin
			prv[nxt[pg]] = prv[pg];
			prv_ok[nxt[pg]] = prv_ok[pg];
		end
		if (free_cnt[r-1] > 0) free_cnt[r-1]--;
	endfunction

	function automatic int page_index(logic [31:0] addr);
		longint unsigned off;
		if (addr < region_base) return -1;
		off = longint'(addr) - longint'(region_base);
		if (off >= longint'(region_pages) * PAGE_BYTES) return -1;
		if (off % PAGE_BYTES != 0) return -1;
		return int'(off / PAGE_BYTES);
	endfunction

	function automatic answer_t predict_answer(logic [2:0] md, logic [31:0] ad, logic [4:0] rk);
		answer_t a;
		int unsigned pg, r, cur, bs, bud, low, start;
		int at;
		a.status = ST_OK;
		a.value = 0;
		case (md)
		MODE_INIT: begin
			if (shadow_pages > MAX_PAGES) a.status = ST_INVAL;
			else begin
				wipe_tables();
				held_blocks.delete();
				region_base = shadow_base;
				region_pages = shadow_pages;
				pg = 0;
				while (pg < region_pages) begin
					for (r = MAX_RANK; r >= 1; r--) begin
						bs = 1 << (r - 1);
						if (bs <= region_pages - pg && (pg & (bs - 1)) == 0) begin
							push_free(r, pg);
							rank_tbl[pg] = 8'(r);
							pg += bs;
							break;
						end
					end
				end
			end
		end
		MODE_ALLOC: begin
			if (rk < 1 || rk > MAX_RANK) a.status = ST_INVAL;
			else begin
				cur = 32'(rk);
				while (cur <= MAX_RANK && !head_ok[cur-1]) cur++;
				if (cur > MAX_RANK) a.status = ST_NOSPACE;
				else begin
					while (cur > rk) begin
						pg = head[cur-1];
						unlink_free(cur, pg);
						cur--;
						bs = 1 << (cur - 1);
						if (pg + bs < MAX_PAGES) begin
							push_free(cur, pg + bs);
							rank_tbl[pg+bs] = 8'(cur);
						end
						push_free(cur, pg);
						if (pg < MAX_PAGES) rank_tbl[pg] = 8'(cur);
					end
					pg = head[rk-1];
					unlink_free(rk, pg);
					if (pg < MAX_PAGES) rank_tbl[pg] = 8'(rk) | ALLOC_MARK;
					a.value = region_base + pg * PAGE_BYTES;
					held_blocks.push_back(a.value);
				end
			end
		end
		MODE_FREE: begin
			at = page_index(ad);
			if (at < 0) a.status = ST_INVAL;
			else begin
				pg = at;
				r = rank_tbl[pg] & RANK_MASK;
				if (r == 0 || (rank_tbl[pg] & ALLOC_MARK) == 0 || r > MAX_RANK)
					a.status = ST_INVAL;
				else begin
					rank_tbl[pg] = 8'(r);
					while (r < MAX_RANK) begin
						bs = 1 << (r - 1);
						bud = pg ^ bs;
						if (bud >= region_pages || rank_tbl[bud] != r) break;
						unlink_free(r, bud);
						low = pg < bud ? pg : bud;
						rank_tbl[low | bs] = 0;
						pg = low;
						r++;
						rank_tbl[pg] = 8'(r);
					end
					push_free(r, pg);
				end
			end
		end
		MODE_QRANK: begin
			at = page_index(ad);
			if (at < 0) a.status = ST_INVAL;
			else begin
				pg = at;
				r = rank_tbl[pg] & RANK_MASK;
				if (r != 0) a.value = r;
				else begin
					a.status = ST_INVAL;
					for (r = MAX_RANK; r >= 1; r--) begin
						start = pg & ~((1 << (r - 1)) - 1);
						if (start != pg && (rank_tbl[start] & RANK_MASK) == r) begin
							a.status = ST_OK;
							a.value = r;
							break;
						end
					end
				end
			end
		end
		MODE_QCNT: begin
			if (rk < 1 || rk > MAX_RANK) a.status = ST_INVAL;
			else a.value = free_cnt[rk-1];
		end
		default: a.status = ST_INVAL;
		endcase
		if (a.status != ST_OK) a.value = 0;
		return a;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, pending_answers.size());
			$display("buddy_page_allocator_core_test: done, errors");
			$finish;
		end
	end

	// result side: random stall and check
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_answers.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected item: status %0d value %h", m_axis_tuser, m_axis_tdata);
			end else begin
				want = pending_answers.pop_front();
				if (want.status !== m_axis_tuser || want.value !== m_axis_tdata) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected status %0d value %h, got status %0d value %h",
							want.status, want.value, m_axis_tuser, m_axis_tdata);
				end
			end
		end
		m_axis_tready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic send_req(logic [2:0] md, logic [31:0] ad, logic [4:0] rk);
		answer_t a;
		if (send_idle > 0 && $urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {3'b000, rk, ad};
		s_axis_tuser <= md;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		a = predict_answer(md, ad, rk);
		pending_answers.push_back(a);
		mode_seen[md]++;
		if (a.status == ST_OK) ok_seen++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_BASE) shadow_base = data;
		else shadow_pages = 32'(data[15:0]);
	endtask

	task automatic set_region(logic [31:0] b, logic [31:0] n);
		drain();
		write_reg(CFG_BASE, b);
		write_reg(CFG_PAGES, n);
		cfg_valid <= 0;
	endtask

	function automatic logic [31:0] page_addr(int unsigned pg);
		return region_base + pg * PAGE_BYTES;
	endfunction

	function automatic logic [4:0] pick_rank();
		int p = $urandom_range(99);
		if (p < 60) return 5'($urandom_range(1, 3));
		if (p < 90) return 5'($urandom_range(1, MAX_RANK));
		return 5'($urandom_range(0, 31));
	endfunction

	function automatic logic [31:0] pick_region_addr();
		if (region_pages == 0 || $urandom_range(9) == 0) return $urandom;
		return page_addr($urandom_range(0, region_pages - 1));
	endfunction

	task automatic test_before_init();
		send_req(MODE_ALLOC, 0, 1);
		send_req(MODE_FREE, 0, 0);
		send_req(MODE_QRANK, 0, 0);
		send_req(MODE_QCNT, 0, 1);
		for (logic [2:0] m = MODE_UNUSED_LO; m <= MODE_UNUSED_HI && m != 0; m++)
			send_req(m, 32'hFFFF_FFFF, 5'h1F);
	endtask

	task automatic test_init_limits();
		set_region(32'h0, 32769);
		send_req(MODE_INIT, 0, 0);
		set_region(32'hFFFF_FFFF, 16'hFFFF);
		send_req(MODE_INIT, 0, 0);
		set_region(32'h0, 0);
		send_req(MODE_INIT, 0, 0);
		send_req(MODE_ALLOC, 0, 1);
		send_req(MODE_QRANK, 0, 0);
	endtask

	task automatic test_small_region();
		logic [31:0] b = 32'h1000_0000;
		set_region(b, 13);
		send_req(MODE_INIT, 0, 0);
		for (int r = 1; r <= 4; r++) send_req(MODE_QCNT, 0, 5'(r));
		send_req(MODE_ALLOC, 0, 0);
		send_req(MODE_ALLOC, 0, 17);
		send_req(MODE_QCNT, 0, 31);
		send_req(MODE_ALLOC, 0, 1);
		send_req(MODE_ALLOC, 0, 2);
		send_req(MODE_QRANK, b + 3 * PAGE_BYTES, 0);
		send_req(MODE_QRANK, b + 9 * PAGE_BYTES, 0);
		send_req(MODE_FREE, b + 5, 0);
		send_req(MODE_FREE, b - PAGE_BYTES, 0);
		send_req(MODE_FREE, b + 13 * PAGE_BYTES, 0);
		send_req(MODE_FREE, b + PAGE_BYTES, 0);
		send_req(MODE_FREE, b, 0);
		send_req(MODE_FREE, b, 0);
		send_req(MODE_ALLOC, 0, 5);
		send_req(MODE_QCNT, 0, 4);
	endtask

	task automatic test_full_region();
		set_region(32'hFFFF_F000, MAX_PAGES);
		send_req(MODE_INIT, 0, 0);
		send_req(MODE_ALLOC, 0, 5'(MAX_RANK));
		send_req(MODE_ALLOC, 0, 1);
		send_req(MODE_QCNT, 0, 1);
		while (held_blocks.size() != 0) send_req(MODE_FREE, held_blocks.pop_front(), 0);
		send_req(MODE_QCNT, 0, 5'(MAX_RANK));
	endtask

	task automatic random_mix(int sidle, int ridle, int n);
		int p, k;
		logic [31:0] b, pages;
		send_idle = sidle;
		recv_idle = ridle;
		for (int part = 0; part < 2; part++) begin
			p = $urandom_range(99);
			pages = p < 70 ? $urandom_range(1, 300) : p < 80 ? 1 :
				p < 90 ? (1 << $urandom_range(0, 10)) : $urandom_range(1000, MAX_PAGES);
			p = $urandom_range(99);
			b = p < 50 ? {20'($urandom_range(0, 32'hF_FFFF)), 12'h000} :
				p < 80 ? $urandom : 32'hFFFF_0000 + $urandom_range(0, 16'hFFFF);
			set_region(b, pages);
			send_req(MODE_INIT, 0, 0);
			for (int i = 0; i < n / 2; i++) begin
				p = $urandom_range(99);
				if (p < 35) send_req(MODE_ALLOC, $urandom, pick_rank());
				else if (p < 65) begin
					if (held_blocks.size() != 0 && $urandom_range(9) != 0) begin
						k = $urandom_range(0, held_blocks.size() - 1);
						b = held_blocks[k];
						held_blocks.delete(k);
						send_req(MODE_FREE, b, 5'($urandom));
					end else send_req(MODE_FREE, pick_region_addr(), 5'($urandom));
				end else if (p < 75) send_req(MODE_QRANK, pick_region_addr(), 5'($urandom));
				else if (p < 85) send_req(MODE_QCNT, $urandom, pick_rank());
				else if (p < 92) send_req(3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)),
						$urandom, 5'($urandom));
				else send_req(3'($urandom_range(MODE_ALLOC, MODE_QCNT)),
						pick_region_addr() + $urandom_range(0, 1), 5'($urandom_range(0, 31)));
			end
		end
	endtask

	initial begin
		shadow_base = 0; shadow_pages = 0; region_base = 0; region_pages = 0;
		wipe_tables();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		send_idle = 27;
		recv_idle = 59;
		test_before_init();
		test_init_limits();
		test_small_region();
		test_full_region();
		random_mix(27, 59, 580);
		random_mix(59, 27, 580);
		random_mix(0, 0, 580);
		drain();
		$display("items: init %0d, alloc %0d, return %0d, rank query %0d, count query %0d, other %0d",
			mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3], mode_seen[4],
			mode_seen[5] + mode_seen[6] + mode_seen[7]);
		$display("%0d answered ok, %0d mismatches, %0d cycles", ok_seen, errors, cycles);
		if (errors == 0)
			$display("buddy_page_allocator_core_test: done, clean");
		else
			$display("buddy_page_allocator_core_test: done, errors");
		$finish;
	end

endmodule
